// ----- sv/lr_expression_parser_assert.svh -----
`ifndef LR_EXPRESSION_PARSER_ASSERT_SVH
`define LR_EXPRESSION_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition that must hold at every clock edge outside reset
`define LRP_ASSERT(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// implication checked at every clock edge outside reset
`define LRP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define LRP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define LRP_ASSERT(lbl, clk, rst, cond, msg)
`define LRP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define LRP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ----- sv/lrp_pkg.sv -----
`default_nettype none

package lrp_pkg;

  localparam int NSTATES     = 30;
  localparam int NTOKENS     = 8;
  localparam int MAX_REDUCE  = 3;
  localparam int QUEUE_DEPTH = 2;

  // input token codes
  typedef enum logic [2:0] {
    TK_NUM    = 3'd0,
    TK_PLUS   = 3'd1,
    TK_MINUS  = 3'd2,
    TK_TIMES  = 3'd3,
    TK_DIVIDE = 3'd4,
    TK_LPAREN = 3'd5,
    TK_RPAREN = 3'd6,
    TK_END    = 3'd7
  } tok_kind_t;

  // result codes
  typedef enum logic [2:0] {
    RES_SHIFT    = 3'd0,
    RES_REDUCE   = 3'd1,
    RES_ACCEPT   = 3'd2,
    RES_ERROR    = 3'd3,
    RES_OVERFLOW = 3'd4
  } res_kind_t;

  // nonterminals, used as goto table column
  typedef enum logic [1:0] {
    NT_E = 2'd0,
    NT_T = 2'd1,
    NT_F = 2'd2
  } nterm_t;

  // action table entry
  typedef enum logic [1:0] {
    OP_ERROR  = 2'd0,
    OP_SHIFT  = 2'd1,
    OP_REDUCE = 2'd2,
    OP_ACCEPT = 2'd3
  } act_op_t;

  typedef struct packed {
    act_op_t    op;
    logic [4:0] code;
  } act_t;

  // classified token as it sits in the request queue
  typedef struct packed {
    tok_kind_t kind;
    logic      is_num;
  } tok_t;

  // execution sequencer states
  typedef enum logic {
    EX_LOOKUP = 1'b0,
    EX_GOTO   = 1'b1
  } ex_state_t;

  function automatic act_t sh(input logic [4:0] n);
    act_t a;
    a.op   = OP_SHIFT;
    a.code = n;
    return a;
  endfunction

  function automatic act_t rd(input logic [4:0] n);
    act_t a;
    a.op   = OP_REDUCE;
    a.code = n;
    return a;
  endfunction

  localparam act_t NA = '{op: OP_ERROR, code: 5'd0};
  localparam act_t AC = '{op: OP_ACCEPT, code: 5'd0};

  // columns: NUM + - * / ( ) end
  localparam act_t ACT_ROM [NSTATES][NTOKENS] = '{
    '{sh(5'd4),  NA,       NA,       NA,        NA,        sh(5'd5),  NA,        NA},
    '{NA,        sh(5'd6), sh(5'd7), NA,        NA,        NA,        NA,        AC},
    '{NA,        rd(5'd2), rd(5'd2), sh(5'd8),  sh(5'd9),  NA,        NA,        rd(5'd2)},
    '{NA,        rd(5'd5), rd(5'd5), rd(5'd5),  rd(5'd5),  NA,        NA,        rd(5'd5)},
    '{NA,        rd(5'd6), rd(5'd6), rd(5'd6),  rd(5'd6),  NA,        NA,        rd(5'd6)},
    '{sh(5'd18), NA,       NA,       NA,        NA,        sh(5'd19), NA,        NA},
    '{sh(5'd4),  NA,       NA,       NA,        NA,        sh(5'd5),  NA,        NA},
    '{sh(5'd4),  NA,       NA,       NA,        NA,        sh(5'd5),  NA,        NA},
    '{sh(5'd4),  NA,       NA,       NA,        NA,        sh(5'd5),  NA,        NA},
    '{sh(5'd4),  NA,       NA,       NA,        NA,        sh(5'd5),  NA,        NA},
    '{NA,        sh(5'd16), sh(5'd17), NA,      NA,        NA,        sh(5'd15), NA},
    '{NA,        rd(5'd0), rd(5'd0), sh(5'd8),  sh(5'd9),  NA,        NA,        rd(5'd0)},
    '{NA,        rd(5'd1), rd(5'd1), sh(5'd8),  sh(5'd9),  NA,        NA,        rd(5'd1)},
    '{NA,        rd(5'd3), rd(5'd3), rd(5'd3),  rd(5'd3),  NA,        NA,        rd(5'd3)},
    '{NA,        rd(5'd4), rd(5'd4), rd(5'd4),  rd(5'd4),  NA,        NA,        rd(5'd4)},
    '{NA,        rd(5'd7), rd(5'd7), rd(5'd7),  rd(5'd7),  NA,        NA,        rd(5'd7)},
    '{sh(5'd18), NA,       NA,       NA,        NA,        sh(5'd19), NA,        NA},
    '{sh(5'd18), NA,       NA,       NA,        NA,        sh(5'd19), NA,        NA},
    '{NA,        rd(5'd6), rd(5'd6), rd(5'd6),  rd(5'd6),  NA,        rd(5'd6),  NA},
    '{sh(5'd18), NA,       NA,       NA,        NA,        sh(5'd19), NA,        NA},
    '{NA,        rd(5'd5), rd(5'd5), rd(5'd5),  rd(5'd5),  NA,        rd(5'd5),  NA},
    '{NA,        rd(5'd2), rd(5'd2), sh(5'd25), sh(5'd26), NA,        rd(5'd2),  NA},
    '{NA,        sh(5'd16), sh(5'd17), NA,      NA,        NA,        sh(5'd29), NA},
    '{NA,        rd(5'd0), rd(5'd0), sh(5'd25), sh(5'd26), NA,        rd(5'd0),  NA},
    '{NA,        rd(5'd1), rd(5'd1), sh(5'd25), sh(5'd26), NA,        rd(5'd1),  NA},
    '{sh(5'd18), NA,       NA,       NA,        NA,        sh(5'd19), NA,        NA},
    '{sh(5'd18), NA,       NA,       NA,        NA,        sh(5'd19), NA,        NA},
    '{NA,        rd(5'd3), rd(5'd3), rd(5'd3),  rd(5'd3),  NA,        rd(5'd3),  NA},
    '{NA,        rd(5'd4), rd(5'd4), rd(5'd4),  rd(5'd4),  NA,        rd(5'd4),  NA},
    '{NA,        rd(5'd7), rd(5'd7), rd(5'd7),  rd(5'd7),  NA,        rd(5'd7),  NA}
  };

  // goto targets for E, T, F; zero means no entry
  localparam logic [4:0] GOTO_ROM [NSTATES][3] = '{
    '{5'd1, 5'd2, 5'd3},   '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},   '{5'd10, 5'd21, 5'd20},
    '{5'd0, 5'd11, 5'd3},  '{5'd0, 5'd12, 5'd3},  '{5'd0, 5'd0, 5'd13},
    '{5'd0, 5'd0, 5'd14},  '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd23, 5'd20}, '{5'd0, 5'd24, 5'd20},
    '{5'd0, 5'd0, 5'd0},   '{5'd22, 5'd21, 5'd20}, '{5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd27},  '{5'd0, 5'd0, 5'd28},
    '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0}
  };

  // action for a state and token; out-of-range states act as state 0
  function automatic act_t act_lookup(input logic [4:0] st, input tok_kind_t tk);
    logic [4:0] s;
    s = (st >= 5'(NSTATES)) ? 5'd0 : st;
    return ACT_ROM[s][tk];
  endfunction

  // goto target for the state under the handle
  function automatic logic [4:0] goto_lookup(input logic [4:0] st, input nterm_t nt);
    logic [4:0] g;
    g = 5'd0;
    if (st < 5'(NSTATES) && nt != 2'd3) begin
      g = GOTO_ROM[st][nt];
    end
    return g;
  endfunction

  // left-hand side of a production
  function automatic nterm_t prod_lhs(input logic [2:0] p);
    nterm_t nt;
    case (p)
      3'd0, 3'd1, 3'd2: nt = NT_E;
      3'd3, 3'd4, 3'd5: nt = NT_T;
      default:          nt = NT_F;
    endcase
    return nt;
  endfunction

  // right-hand side length of a production
  function automatic logic [1:0] prod_len(input logic [2:0] p);
    logic [1:0] n;
    case (p)
      3'd2, 3'd5, 3'd6: n = 2'd1;
      default:          n = 2'd3;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- sv/lrp_front.sv -----
`default_nettype none

module lrp_front import lrp_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [2:0]                    token_kind,
  input  wire logic signed [VALUE_WIDTH-1:0] num_value,
  output      logic                          q_valid,
  output      tok_t                          q_tok,
  output      logic signed [VALUE_WIDTH-1:0] q_value,
  input  wire logic                          q_pop
);

  localparam int QIW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  tok_t                          tok_mem [QUEUE_DEPTH];
  logic signed [VALUE_WIDTH-1:0] val_mem [QUEUE_DEPTH];
  logic [QIW-1:0]                wptr;
  logic [QIW-1:0]                rptr;
  logic [QCW-1:0]                count;
  tok_t                          in_tok;
  logic                          push;
  logic                          pop;

  // classify the incoming request
  always_comb begin
    in_tok.kind   = tok_kind_t'(token_kind);
    in_tok.is_num = (tok_kind_t'(token_kind) == TK_NUM);
  end

  assign in_ready = (count != QCW'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // queue storage, the value is zeroed for anything but a number
  always_ff @(posedge clk) begin
    if (push) begin
      tok_mem[wptr] <= in_tok;
      val_mem[wptr] <= in_tok.is_num ? num_value : '0;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QIW'(QUEUE_DEPTH - 1)) ? '0 : wptr + QIW'(1);
      end
      if (pop) begin
        rptr <= (rptr == QIW'(QUEUE_DEPTH - 1)) ? '0 : rptr + QIW'(1);
      end
      if (push && !pop) begin
        count <= count + QCW'(1);
      end else if (pop && !push) begin
        count <= count - QCW'(1);
      end
    end
  end

  assign q_valid = (count != '0);
  assign q_tok   = tok_mem[rptr];
  assign q_value = val_mem[rptr];

endmodule

`default_nettype wire

// ----- sv/lrp_exec.sv -----
`default_nettype none
`include "lr_expression_parser_assert.svh"

module lrp_exec import lrp_pkg::*; #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire tok_t                          q_tok,
  input  wire logic signed [VALUE_WIDTH-1:0] q_value,
  output      logic                          q_pop,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [2:0]                    kind,
  output      logic [2:0]                    production,
  output      logic [4:0]                    new_state,
  output      logic signed [VALUE_WIDTH-1:0] shifted_value,
  output      logic                          last
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int IW  = $clog2(STACK_DEPTH);

  // stack memory, entry 0 is never written and reads as state 0
  logic [4:0]     stack_mem [STACK_DEPTH];
  logic [4:0]     rdata;

  ex_state_t      state;
  ex_state_t      state_next;
  logic [SPW-1:0] sp;
  logic [SPW-1:0] sp_next;
  logic [4:0]     top;
  logic [4:0]     top_next;
  logic [1:0]     red_cnt;
  logic [1:0]     red_cnt_next;
  logic [2:0]     prod;
  logic [2:0]     prod_next;
  logic [IW-1:0]  wr_base;
  logic [IW-1:0]  wr_base_next;
  logic           rd_zero;
  logic           rd_zero_next;

  act_t           act;
  logic [1:0]     len;
  logic [SPW-1:0] under_sp;
  logic           red_ok;
  logic           can_emit;
  logic [4:0]     under;
  logic [4:0]     goto_st;

  logic           rd_en;
  logic [IW-1:0]  rd_addr;
  logic           wr_en;
  logic [IW-1:0]  wr_addr;
  logic [4:0]     wr_data;

  logic                          emit;
  res_kind_t                     emit_kind;
  logic [2:0]                    emit_prod;
  logic [4:0]                    emit_state;
  logic signed [VALUE_WIDTH-1:0] emit_val;
  logic                          emit_last;

  // table lookup on the top of stack and the queued token
  assign act      = act_lookup(top, q_tok.kind);
  assign len      = prod_len(act.code[2:0]);
  assign under_sp = sp - SPW'(len);
  assign red_ok   = (act.op == OP_REDUCE) && (red_cnt != 2'(MAX_REDUCE))
                    && (sp > SPW'(len));
  assign can_emit = !out_valid || out_ready;
  assign under    = rd_zero ? 5'd0 : rdata;
  assign goto_st  = goto_lookup(under, prod_lhs(prod));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      EX_LOOKUP: begin
        if (q_valid && red_ok) begin
          state_next = EX_GOTO;
        end
      end
      EX_GOTO: begin
        if (can_emit) begin
          state_next = EX_LOOKUP;
        end
      end
      default: state_next = EX_LOOKUP;
    endcase
  end

  // sequencer outputs and stack updates
  always_comb begin
    sp_next      = sp;
    top_next     = top;
    red_cnt_next = red_cnt;
    prod_next    = prod;
    wr_base_next = wr_base;
    rd_zero_next = rd_zero;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;
    q_pop        = 1'b0;
    emit         = 1'b0;
    emit_kind    = RES_ERROR;
    emit_prod    = 3'd0;
    emit_state   = 5'd0;
    emit_val     = '0;
    emit_last    = 1'b1;
    case (state)
      EX_LOOKUP: begin
        if (q_valid) begin
          if (red_ok) begin
            // read the state under the handle
            rd_en        = 1'b1;
            rd_addr      = IW'(under_sp - SPW'(1));
            rd_zero_next = (under_sp == SPW'(1));
            wr_base_next = IW'(under_sp);
            prod_next    = act.code[2:0];
          end else if (can_emit) begin
            emit  = 1'b1;
            q_pop = 1'b1;
            red_cnt_next = 2'd0;
            if (act.op == OP_SHIFT && sp < SPW'(STACK_DEPTH)) begin
              emit_kind  = RES_SHIFT;
              emit_state = act.code;
              emit_val   = q_value;
              wr_en      = 1'b1;
              wr_addr    = IW'(sp);
              wr_data    = act.code;
              sp_next    = sp + SPW'(1);
              top_next   = act.code;
            end else begin
              if (act.op == OP_SHIFT) begin
                emit_kind = RES_OVERFLOW;
              end else if (act.op == OP_ACCEPT) begin
                emit_kind = RES_ACCEPT;
              end else begin
                emit_kind = RES_ERROR;
              end
              sp_next  = SPW'(1);
              top_next = 5'd0;
            end
          end
        end
      end
      EX_GOTO: begin
        if (can_emit) begin
          emit = 1'b1;
          if (goto_st == 5'd0) begin
            // missing goto entry closes the token as an error
            q_pop        = 1'b1;
            red_cnt_next = 2'd0;
            sp_next      = SPW'(1);
            top_next     = 5'd0;
          end else begin
            emit_kind    = RES_REDUCE;
            emit_prod    = prod;
            emit_state   = goto_st;
            emit_last    = 1'b0;
            wr_en        = 1'b1;
            wr_addr      = wr_base;
            wr_data      = goto_st;
            sp_next      = SPW'(wr_base) + SPW'(1);
            top_next     = goto_st;
            red_cnt_next = red_cnt + 2'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // stack memory ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= stack_mem[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= EX_LOOKUP;
      sp      <= SPW'(1);
      top     <= 5'd0;
      red_cnt <= 2'd0;
    end else begin
      state   <= state_next;
      sp      <= sp_next;
      top     <= top_next;
      red_cnt <= red_cnt_next;
    end
  end

  // handle bookkeeping between lookup and goto
  always_ff @(posedge clk) begin
    prod    <= prod_next;
    wr_base <= wr_base_next;
    rd_zero <= rd_zero_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind          <= emit_kind;
      production    <= emit_prod;
      new_state     <= emit_state;
      shifted_value <= emit_val;
      last          <= emit_last;
    end
  end

  `LRP_ASSERT(a_sp_range, clk, rst, (sp != '0) && (sp <= SPW'(STACK_DEPTH)), "stack pointer out of range")
  `LRP_ASSERT(a_top_valid, clk, rst, top < 5'(NSTATES), "top of stack is not a parser state")
  `LRP_ASSERT_IMP(a_goto_cnt, clk, rst, state == EX_GOTO, red_cnt != 2'(MAX_REDUCE), "reduction chain too long")
  `LRP_ASSERT_IMP(a_reduce_src, clk, rst, emit && !emit_last, state == EX_GOTO && !q_pop, "reduce outside goto step")
  `LRP_ASSERT_NEXT(a_clear, clk, rst, emit && emit_last && emit_kind != RES_SHIFT, sp == SPW'(1) && top == 5'd0, "stack not cleared after close")

endmodule

`default_nettype wire

// ----- sv/lr_expression_parser.sv -----
// LR(1) shift-reduce parser for E->E+T|E-T|T, T->T*F|T/F|F, F->NUM|(E), one token per
// request on the input channel. Each token yields zero to three reduce results
// (production and goto state) followed by one closing result marked last: shift
// (carrying the NUM value), accept, syntax error or stack overflow; after any
// closing result but a shift the stack holds state 0 alone. Tokens enter a
// two-entry queue, so input is taken while the parser works and while a result
// waits in the output register. Each reduction takes a lookup step on the action
// table and the registered read of the stack memory, then a goto step on the goto
// table and the push; the closing result takes one more lookup step. The goto and
// closing steps wait while the output register holds a result not yet taken. The
// stack lives in a STACK_DEPTH-entry memory and needs no clearing pass after reset.
`default_nettype none

module lr_expression_parser import lrp_pkg::*; #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [2:0]                    token_kind,
  input  wire logic signed [VALUE_WIDTH-1:0] num_value,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [2:0]                    kind,
  output      logic [2:0]                    production,
  output      logic [4:0]                    new_state,
  output      logic signed [VALUE_WIDTH-1:0] shifted_value,
  output      logic                          last
);

  logic                          q_valid;
  tok_t                          q_tok;
  logic signed [VALUE_WIDTH-1:0] q_value;
  logic                          q_pop;

  // token intake and queue
  lrp_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .token_kind (token_kind),
    .num_value  (num_value),
    .q_valid    (q_valid),
    .q_tok      (q_tok),
    .q_value    (q_value),
    .q_pop      (q_pop)
  );

  // parse engine with stack and output register
  lrp_exec #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_exec (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_tok         (q_tok),
    .q_value       (q_value),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .production    (production),
    .new_state     (new_state),
    .shifted_value (shifted_value),
    .last          (last)
  );

endmodule

`default_nettype wire
